// ===== rtl/sqrw_pkg.sv =====
// ============================================================================
// sqrw_pkg
// Shared types, register indexes, command/status bundles and serial-number
// arithmetic for the sequence reorder window.
// ============================================================================
package sqrw_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_PULL = 2'd1,
        OP_PEEK = 2'd2,
        OP_DROP = 2'd3
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DONE    = 2'd0,
        KIND_DROP    = 2'd1,
        KIND_DELIVER = 2'd2,
        KIND_MISS    = 2'd3
    } kind_t;

    // Source of the sequence number and payload of an outgoing beat
    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_ITEM  = 2'd1,
        SRC_SLOT  = 2'd2,
        SRC_EVICT = 2'd3
    } src_t;

    // Configuration register indexes
    localparam logic [1:0] REG_SERIAL_WIDTH = 2'd0;
    localparam logic [1:0] REG_EVICT_OLDEST = 2'd1;
    localparam logic [1:0] REG_REPORT_DROPS = 2'd2;
    localparam logic [1:0] REG_START_SEQ    = 2'd3;

    typedef struct packed {
        op_t         operation;
        logic [31:0] seq_num;
        logic [5:0]  slot_offset;
        logic [31:0] payload;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] out_seq;
        logic [31:0] out_payload;
        logic [5:0]  fill;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PUSH_REPORT,
        ST_OVERFLOW,
        ST_EVICT_SIM,
        ST_EXTEND_SIM,
        ST_EVICT_READ,
        ST_EVICT_OUT,
        ST_PUSH_COMMIT,
        ST_HIT_OUT,
        ST_TRIM,
        ST_DROP_OUT,
        ST_DONE,
        ST_MISS
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  capture;      // latch the input item and window snapshot
        logic  decode;       // read the addressed slot, latch its number
        logic  fill_dec;     // working fill minus one (pull hit)
        logic  clear_slot;   // clear mark of the decoded slot
        logic  store;        // write the pushed item and set its mark
        logic  rebase;       // working begin takes the pushed number
        logic  ev_init;      // start the eviction count
        logic  ev_step;      // evict one slot from the working window
        logic  ext_init;     // start the extension count
        logic  ext_rebase;   // on ext_init, an empty window rebases
        logic  ext_step;     // extend the working window by one slot
        logic  ev_read;      // read the next evicted slot
        logic  ev_next;      // clear that slot and advance
        logic  trim_step;    // drop one trailing empty slot
        logic  commit_push;  // write back begin and fill, clear new slots
        logic  commit_pull;  // advance begin past the delivered head
        logic  commit_fill;  // write back fill
        logic  emit;         // load an output beat
        kind_t kind;
        src_t  src;
        logic  last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        op_t  op;
        logic inwin;
        logic dup;
        logic stale;
        logic past_end;
        logic window_empty;
        logic evict_oldest;
        logic report_drops;
        logic hit;
        logic drop_tail;
        logic ovf;
        logic ext_more;
        logic ev_any;
        logic ev_last;
        logic ev_present;
        logic trim_more;
    } status_t;

    function automatic logic [31:0] ser_mask(input logic mode);
        return mode ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    endfunction

    function automatic logic [31:0] ser_add(input logic [31:0] a, input logic [31:0] b,
                                            input logic mode);
        return (a + b) & ser_mask(mode);
    endfunction

    function automatic logic ser_lt(input logic [31:0] a, input logic [31:0] b,
                                    input logic mode);
        logic [31:0] m;
        logic [31:0] half;
        logic [31:0] am;
        logic [31:0] bm;
        m    = ser_mask(mode);
        half = mode ? 32'h8000_0000 : 32'h0000_8000;
        am   = a & m;
        bm   = b & m;
        return ((am < bm) && ((bm - am) < half)) || ((am > bm) && ((am - bm) > half));
    endfunction

    function automatic logic ser_ge(input logic [31:0] a, input logic [31:0] b,
                                    input logic mode);
        return ((a & ser_mask(mode)) == (b & ser_mask(mode))) || ser_lt(b, a, mode);
    endfunction

endpackage

// ===== rtl/sequence_reorder_window_unit.sv =====
// ============================================================================
// sequence_reorder_window_unit
// Items are handled one at a time: a new item is accepted only after the last
// one's final result beat has loaded. Pushes may extend the window or evict the
// oldest slots; evicted slots are walked through the single read port, and a
// drop at the tail trims trailing empty slots. A stalled beat holds the item.
// Reset clears marks, fill, start and configuration; slot data is unset.
// ============================================================================
module sequence_reorder_window_unit #(
    parameter int DEPTH_LOG2   = 5,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sqrw_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sqrw_pkg::out_item_t  out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import sqrw_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    sqrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .st       (st)
    );

    sqrw_dp #(
        .DEPTH_LOG2   (DEPTH_LOG2),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== rtl/sqrw_dp.sv =====
// ============================================================================
// sqrw_dp
// Reorder window datapath: configuration, slot marks, slot memory, working
// window registers, serial compares and the output beat register.
// ============================================================================
module sqrw_dp #(
    parameter int DEPTH_LOG2   = 5,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sqrw_pkg::in_item_t   in_data,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output sqrw_pkg::out_item_t  out_data,
    input  sqrw_pkg::cmd_t       cmd,
    output sqrw_pkg::status_t    st
);
    import sqrw_pkg::*;

    localparam int SLOTS   = 1 << DEPTH_LOG2;
    localparam int IDX_W   = DEPTH_LOG2;
    localparam int CNT_W   = DEPTH_LOG2 + 1;
    localparam int STORE_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [31:0]      SLOTS_W = 32'(SLOTS);

    // Configuration and window state
    logic                 mode_reg;
    logic                 evict_reg;
    logic                 report_reg;
    logic [31:0]          start_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [SLOTS-1:0]     present_reg;
    logic [SLOTS-1:0]     present_next;
    logic [STORE_W-1:0]   mem [SLOTS];
    logic [STORE_W-1:0]   rdata_reg;

    // Working registers of one item
    op_t                  op_reg;
    logic [31:0]          s_reg;
    logic [5:0]           off_reg;
    logic [STORE_W-1:0]   pay_reg;
    logic [31:0]          wb_reg;
    logic [CNT_W-1:0]     wf_reg;
    logic [31:0]          ob_reg;
    logic [CNT_W-1:0]     ev_cnt_reg;
    logic [IDX_W-1:0]     k_reg;
    logic [31:0]          ext_end_reg;
    logic [IDX_W-1:0]     ext_start_reg;
    logic [CNT_W-1:0]     ext_cnt_reg;
    logic [31:0]          cur_seq_reg;

    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 cfg_start;
    logic [31:0]          s1;
    logic [31:0]          end_w;
    logic [31:0]          cap_end;
    logic [31:0]          dec_seq;
    logic [IDX_W-1:0]     dec_idx;
    logic [IDX_W-1:0]     s_idx;
    logic [31:0]          ev_seq;
    logic [IDX_W-1:0]     ev_idx;
    logic [IDX_W-1:0]     cur_idx;
    logic [IDX_W-1:0]     trim_idx;
    logic [SLOTS-1:0]     ext_mask;
    logic [31:0]          nb;
    logic                 out_free;
    out_item_t            beat;

    assign cfg_start = cfg_valid && (cfg_index == REG_START_SEQ);

    // Serial arithmetic on the working window
    assign s1        = ser_add(s_reg, 32'd1, mode_reg);
    assign end_w     = ser_add(wb_reg, 32'(wf_reg), mode_reg);
    assign cap_end   = ser_add(wb_reg, SLOTS_W, mode_reg);
    assign dec_seq   = (op_reg == OP_PULL) ? wb_reg
                                           : ser_add(wb_reg, 32'(off_reg), mode_reg);
    assign dec_idx   = dec_seq[IDX_W-1:0];
    assign s_idx     = s_reg[IDX_W-1:0];
    assign ev_seq    = ser_add(ob_reg, 32'(k_reg), mode_reg);
    assign ev_idx    = ev_seq[IDX_W-1:0];
    assign cur_idx   = cur_seq_reg[IDX_W-1:0];
    assign trim_idx  = wb_reg[IDX_W-1:0] + wf_reg[IDX_W-1:0] - IDX_W'(1);
    assign nb        = (cmd.ext_rebase && (wf_reg == '0)) ? s_reg : wb_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Mark the slots opened by the extension
    always_comb
    begin
        logic [IDX_W-1:0] span;
        for (int i = 0; i < SLOTS; i++)
        begin
            span        = IDX_W'(i) - ext_start_reg;
            ext_mask[i] = CNT_W'(span) < ext_cnt_reg;
        end
    end

    // Status toward the controller
    always_comb
    begin
        st              = '0;
        st.out_free     = out_free;
        st.op           = op_reg;
        st.inwin        = ser_ge(s_reg, wb_reg, mode_reg) && ser_lt(s_reg, end_w, mode_reg);
        st.dup          = present_reg[s_idx];
        st.stale        = ser_lt(s_reg, wb_reg, mode_reg);
        st.past_end     = ser_ge(s_reg, end_w, mode_reg);
        st.window_empty = (wf_reg == '0);
        st.evict_oldest = evict_reg;
        st.report_drops = report_reg;
        if (op_reg == OP_PULL)
        begin
            st.hit = (wf_reg != '0) && present_reg[dec_idx];
        end
        else
        begin
            st.hit = (off_reg < 6'(wf_reg)) && present_reg[dec_idx];
        end
        st.drop_tail    = (off_reg == (6'(wf_reg) - 6'd1));
        st.ovf          = ser_lt(cap_end, s1, mode_reg);
        st.ext_more     = (wf_reg != SLOTS_C) && ser_lt(ext_end_reg, s1, mode_reg);
        st.ev_any       = (ev_cnt_reg != '0);
        st.ev_last      = ((CNT_W'(k_reg) + CNT_W'(1)) == ev_cnt_reg);
        st.ev_present   = present_reg[ev_idx];
        st.trim_more    = (wf_reg != '0) && !present_reg[trim_idx];
    end

    // Next slot marks
    always_comb
    begin
        present_next = present_reg;
        if (cfg_start)
        begin
            present_next = '0;
        end
        else
        begin
            if (cmd.clear_slot)
            begin
                present_next[dec_idx] = 1'b0;
            end
            if (cmd.ev_next)
            begin
                present_next[ev_idx] = 1'b0;
            end
            if (cmd.commit_pull)
            begin
                present_next[cur_idx] = 1'b0;
            end
            if (cmd.commit_push)
            begin
                present_next = present_next & ~ext_mask;
            end
            if (cmd.store)
            begin
                present_next[s_idx] = 1'b1;
            end
        end
    end

    // Configuration, window state and slot marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            evict_reg   <= 1'b0;
            report_reg  <= 1'b0;
            start_reg   <= '0;
            fill_reg    <= '0;
            present_reg <= '0;
        end
        else
        begin
            present_reg <= present_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SERIAL_WIDTH: mode_reg   <= cfg_data[0];
                    REG_EVICT_OLDEST: evict_reg  <= cfg_data[0];
                    REG_REPORT_DROPS: report_reg <= cfg_data[0];
                    REG_START_SEQ:
                    begin
                        start_reg <= cfg_data;
                        fill_reg  <= '0;
                    end
                    default: ;
                endcase
            end
            else if (cmd.commit_push)
            begin
                start_reg <= wb_reg;
                fill_reg  <= wf_reg;
            end
            else if (cmd.commit_pull)
            begin
                start_reg <= ser_add(cur_seq_reg, 32'd1, mode_reg);
                fill_reg  <= wf_reg;
            end
            else if (cmd.commit_fill)
            begin
                fill_reg <= wf_reg;
            end
        end
    end

    // Working registers of the item in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_PUSH;
            s_reg         <= '0;
            off_reg       <= '0;
            pay_reg       <= '0;
            wb_reg        <= '0;
            wf_reg        <= '0;
            ob_reg        <= '0;
            ev_cnt_reg    <= '0;
            k_reg         <= '0;
            ext_end_reg   <= '0;
            ext_start_reg <= '0;
            ext_cnt_reg   <= '0;
            cur_seq_reg   <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                op_reg     <= in_data.operation;
                s_reg      <= in_data.seq_num & ser_mask(mode_reg);
                off_reg    <= in_data.slot_offset;
                pay_reg    <= in_data.payload[STORE_W-1:0];
                wb_reg     <= start_reg & ser_mask(mode_reg);
                wf_reg     <= fill_reg;
                ev_cnt_reg <= '0;
            end
            if (cmd.decode)
            begin
                cur_seq_reg <= dec_seq;
            end
            if (cmd.fill_dec || cmd.trim_step)
            begin
                wf_reg <= wf_reg - CNT_W'(1);
            end
            if (cmd.rebase)
            begin
                wb_reg <= s_reg;
            end
            // Evict: begin advances, fill shrinks
            if (cmd.ev_init)
            begin
                ob_reg     <= wb_reg;
                ev_cnt_reg <= '0;
                k_reg      <= '0;
            end
            if (cmd.ev_step)
            begin
                wb_reg     <= ser_add(wb_reg, 32'd1, mode_reg);
                wf_reg     <= wf_reg - CNT_W'(1);
                ev_cnt_reg <= ev_cnt_reg + CNT_W'(1);
            end
            // Extend: end advances, fill grows
            if (cmd.ext_init)
            begin
                wb_reg        <= nb;
                ext_end_reg   <= ser_add(nb, 32'(wf_reg), mode_reg);
                ext_start_reg <= nb[IDX_W-1:0] + wf_reg[IDX_W-1:0];
                ext_cnt_reg   <= '0;
            end
            if (cmd.ext_step)
            begin
                ext_end_reg <= ser_add(ext_end_reg, 32'd1, mode_reg);
                wf_reg      <= wf_reg + CNT_W'(1);
                ext_cnt_reg <= ext_cnt_reg + CNT_W'(1);
            end
            if (cmd.ev_next)
            begin
                k_reg <= k_reg + IDX_W'(1);
            end
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[s_idx] <= pay_reg;
        end
        if (cmd.decode || cmd.ev_read)
        begin
            rdata_reg <= mem[cmd.ev_read ? ev_idx : dec_idx];
        end
    end

    // Assemble the outgoing beat
    always_comb
    begin
        beat      = '0;
        beat.kind = cmd.kind;
        beat.fill = 6'(wf_reg);
        beat.last = cmd.last;
        case (cmd.src)
            SRC_ITEM:
            begin
                beat.out_seq     = s_reg;
                beat.out_payload = 32'(pay_reg);
            end
            SRC_SLOT:
            begin
                beat.out_seq     = cur_seq_reg;
                beat.out_payload = 32'(rdata_reg);
            end
            SRC_EVICT:
            begin
                beat.out_seq     = ev_seq;
                beat.out_payload = 32'(rdata_reg);
            end
            default: ;
        endcase
    end

    // Output register: load when empty or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && out_free)
        begin
            out_reg <= beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Window never spans more than the slot count
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= SLOTS_C)
        else $error("window fill beyond capacity");

    // An empty window holds no marked slot
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (present_reg == '0))
        else $error("marked slot outside an empty window");

    // Eviction walk stays within the counted slots
    a_evict_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ev_next |-> (CNT_W'(k_reg) < ev_cnt_reg))
        else $error("eviction walk past its count");

endmodule

// ===== rtl/sqrw_ctrl.sv =====
// ============================================================================
// sqrw_ctrl
// Reorder window controller: sequences decode, eviction and extension
// counting, eviction reports, trimming and result beats.
// ============================================================================
module sqrw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output sqrw_pkg::cmd_t     cmd,
    input  sqrw_pkg::status_t  st
);
    import sqrw_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (st.op == OP_PUSH)
                begin
                    if (st.inwin)
                    begin
                        if (st.dup)
                        begin
                            state_next = ST_PUSH_REPORT;
                        end
                        else
                        begin
                            // Store in place and finish
                            cmd.store       = 1'b1;
                            cmd.emit        = st.out_free;
                            cmd.kind        = KIND_DONE;
                            cmd.last        = 1'b1;
                            cmd.commit_fill = st.out_free;
                            state_next      = st.out_free ? ST_IDLE : ST_DONE;
                        end
                    end
                    else if (st.stale)
                    begin
                        state_next = ST_PUSH_REPORT;
                    end
                    else if (!st.past_end)
                    begin
                        if (st.window_empty && st.evict_oldest)
                        begin
                            cmd.rebase = 1'b1;
                            state_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            state_next = ST_PUSH_REPORT;
                        end
                    end
                    else
                    begin
                        state_next = ST_OVERFLOW;
                    end
                end
                else if (st.hit)
                begin
                    case (st.op)
                        OP_PULL:
                        begin
                            cmd.fill_dec = 1'b1;
                            state_next   = ST_HIT_OUT;
                        end
                        OP_PEEK:
                        begin
                            state_next = ST_HIT_OUT;
                        end
                        default:
                        begin
                            cmd.clear_slot = 1'b1;
                            state_next     = st.drop_tail ? ST_TRIM : ST_DROP_OUT;
                        end
                    endcase
                end
                else
                begin
                    cmd.emit   = st.out_free;
                    cmd.kind   = KIND_MISS;
                    cmd.last   = 1'b1;
                    state_next = st.out_free ? ST_IDLE : ST_MISS;
                end
            end

            ST_PUSH_REPORT:
            begin
                if (st.report_drops)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_DROP;
                    cmd.src  = SRC_ITEM;
                    if (st.out_free)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_OVERFLOW:
            begin
                if (st.ovf && !st.evict_oldest)
                begin
                    state_next = ST_PUSH_REPORT;
                end
                else if (st.ovf)
                begin
                    cmd.ev_init = 1'b1;
                    state_next  = ST_EVICT_SIM;
                end
                else
                begin
                    cmd.ext_init = 1'b1;
                    state_next   = ST_EXTEND_SIM;
                end
            end

            // Count the oldest slots to evict
            ST_EVICT_SIM:
            begin
                if (st.ovf && !st.window_empty)
                begin
                    cmd.ev_step = 1'b1;
                end
                else
                begin
                    cmd.ext_init   = 1'b1;
                    cmd.ext_rebase = 1'b1;
                    state_next     = ST_EXTEND_SIM;
                end
            end

            // Count the slots the window grows by
            ST_EXTEND_SIM:
            begin
                if (st.ext_more)
                begin
                    cmd.ext_step = 1'b1;
                end
                else
                begin
                    state_next = st.ev_any ? ST_EVICT_READ : ST_PUSH_COMMIT;
                end
            end

            ST_EVICT_READ:
            begin
                cmd.ev_read = 1'b1;
                state_next  = ST_EVICT_OUT;
            end

            // Report a present evicted slot when drops are reported, then clear it
            ST_EVICT_OUT:
            begin
                if (st.ev_present && st.report_drops)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_DROP;
                    cmd.src     = SRC_EVICT;
                    cmd.ev_next = st.out_free;
                    if (st.out_free)
                    begin
                        state_next = st.ev_last ? ST_PUSH_COMMIT : ST_EVICT_READ;
                    end
                end
                else
                begin
                    cmd.ev_next = 1'b1;
                    state_next  = st.ev_last ? ST_PUSH_COMMIT : ST_EVICT_READ;
                end
            end

            ST_PUSH_COMMIT:
            begin
                cmd.commit_push = 1'b1;
                cmd.store       = 1'b1;
                state_next      = ST_DONE;
            end

            ST_HIT_OUT:
            begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_DELIVER;
                cmd.src  = SRC_SLOT;
                cmd.last = 1'b1;
                if (st.out_free)
                begin
                    cmd.commit_pull = (st.op == OP_PULL);
                    state_next      = ST_IDLE;
                end
            end

            // Drop trailing empty slots
            ST_TRIM:
            begin
                if (st.trim_more)
                begin
                    cmd.trim_step = 1'b1;
                end
                else
                begin
                    state_next = ST_DROP_OUT;
                end
            end

            ST_DROP_OUT:
            begin
                if (st.report_drops)
                begin
                    cmd.emit = 1'b1;
                    cmd.kind = KIND_DROP;
                    cmd.src  = SRC_SLOT;
                    if (st.out_free)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_DONE;
                cmd.last = 1'b1;
                if (st.out_free)
                begin
                    cmd.commit_fill = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_MISS:
            begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_MISS;
                cmd.last = 1'b1;
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A beat that cannot load holds the controller in place
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !st.out_free) |=> $stable(state_reg))
        else $error("controller moved past an unloaded beat");

    // An accepted item is decoded next
    a_capture_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_DECODE))
        else $error("accepted item not decoded");

    // Window commits never coincide
    a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit_push && cmd.commit_pull))
        else $error("two window commits in one cycle");

endmodule
